@@ hdl/rgbfb_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbfb_pkg
// Shared types and constants for the RGB565 fill and blend unit.
// ----------------------------------------------------------------------------
package rgbfb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 13;
    localparam int WEIGHT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd4;

    localparam logic [1:0] MODE_SOLID   = 2'd0;
    localparam logic [1:0] MODE_OPACITY = 2'd1;
    localparam logic [1:0] MODE_MASKED  = 2'd2;

    localparam logic [7:0]  OPACITY_FULL = 8'd255;
    localparam logic [7:0]  ALPHA_SOLID  = 8'd253;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'd2;
    localparam logic [8:0]  WEIGHT_ROUND = 9'd4;
    localparam int          WEIGHT_SHIFT = 5;
    localparam logic [31:0] SPREAD_MASK  = 32'h07E0_F81F;

    typedef enum logic [1:0] {
        OP_KEEP,
        OP_FILL,
        OP_BLEND
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [WEIGHT_W-1:0] weight;
        logic [15:0]         pixel;
        logic                row_end;
        logic                region_end;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

@@ hdl/rgb565_fill_blend_unit.sv @@
// ----------------------------------------------------------------------------
// rgb565_fill_blend_unit
// Fills or alpha-blends a color over an RGB565 region in raster order.
// ----------------------------------------------------------------------------
// Input side: push a destination pixel and its mask byte while full is low.
// Result side: while empty is low the oldest result sits on out_pixel,
// write_enable, row_end and region_end; pop takes it.
// Exactly one result per pixel, in order. A pushed pixel passes through
// the queue, then the output register, before it shows on the result
// ports. Throughput is one pixel per clock while the receiver keeps popping;
// the blend multiplier in the back part sets the cycle.
// The front part keeps the column and row position and classifies each
// pixel; a short queue lets the front keep taking pixels while the
// receiver stalls, until the queue fills and full rises.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// next edge. The user must make them while no pixel is in flight; the
// block does not enforce it. Reset empties the queue and output, zeroes
// the position and loads mode 0, color 0, opacity 255 and a one by one region.
// ----------------------------------------------------------------------------
module rgb565_fill_blend_unit #(
    parameter int MAX_DIM     = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rgbfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbfb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [15:0]                      dst_pixel,
    input  logic [7:0]                       mask_value,
    input  logic                             pop,
    output logic                             empty,
    output logic [15:0]                      out_pixel,
    output logic                             write_enable,
    output logic                             row_end,
    output logic                             region_end
);

    logic [1:0]                  mode_reg;
    logic [15:0]                 color_reg;
    logic [7:0]                  opacity_reg;
    logic [rgbfb_pkg::DIM_W-1:0] width_reg;
    logic [rgbfb_pkg::DIM_W-1:0] height_reg;

    rgbfb_pkg::qstat_t qstat;
    rgbfb_pkg::entry_t wr_entry, rd_entry;
    logic              q_write, q_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rgbfb_pkg::MODE_SOLID;
            color_reg   <= '0;
            opacity_reg <= rgbfb_pkg::OPACITY_FULL;
            width_reg   <= rgbfb_pkg::DIM_W'(1);
            height_reg  <= rgbfb_pkg::DIM_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rgbfb_pkg::CFG_MODE:       mode_reg    <= cfg_data[1:0];
                rgbfb_pkg::CFG_FILL_COLOR: color_reg   <= cfg_data;
                rgbfb_pkg::CFG_OPACITY:    opacity_reg <= cfg_data[7:0];
                rgbfb_pkg::CFG_WIDTH:      width_reg   <= cfg_data[rgbfb_pkg::DIM_W-1:0];
                rgbfb_pkg::CFG_HEIGHT:     height_reg  <= cfg_data[rgbfb_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full = qstat.full;

    rgbfb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .qstat         (qstat),
        .mode          (mode_reg),
        .opacity       (opacity_reg),
        .region_width  (width_reg),
        .region_height (height_reg),
        .dst_pixel     (dst_pixel),
        .mask_value    (mask_value),
        .q_write       (q_write),
        .q_entry       (wr_entry)
    );

    rgbfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_write),
        .wr_entry (wr_entry),
        .rd       (q_read),
        .rd_entry (rd_entry),
        .qstat    (qstat)
    );

    rgbfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .q_entry      (rd_entry),
        .q_read       (q_read),
        .fill_color   (color_reg),
        .pop          (pop),
        .empty        (empty),
        .out_pixel    (out_pixel),
        .write_enable (write_enable),
        .row_end      (row_end),
        .region_end   (region_end)
    );

    a_region_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && region_end) |-> row_end)
        else $error("region end without row end");

    a_keep_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        q_read && (rd_entry.op == rgbfb_pkg::OP_KEEP) |=> !write_enable)
        else $error("kept pixel flagged for write");

    a_fill_color: assert property (@(posedge clk) disable iff (!rst_n)
        q_read && (rd_entry.op == rgbfb_pkg::OP_FILL) |=> out_pixel == $past(color_reg))
        else $error("fill result differs from color");

endmodule

@@ hdl/rgbfb_front.sv @@
// ----------------------------------------------------------------------------
// rgbfb_front
// Accepts pixels, tracks the raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module rgbfb_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  rgbfb_pkg::qstat_t           qstat,
    input  logic [1:0]                  mode,
    input  logic [7:0]                  opacity,
    input  logic [rgbfb_pkg::DIM_W-1:0] region_width,
    input  logic [rgbfb_pkg::DIM_W-1:0] region_height,
    input  logic [15:0]                 dst_pixel,
    input  logic [7:0]                  mask_value,
    output logic                        q_write,
    output rgbfb_pkg::entry_t           q_entry
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = (CW + 1 > rgbfb_pkg::DIM_W) ? CW + 1 : rgbfb_pkg::DIM_W;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    logic [EW-1:0] dim_w, dim_h;
    logic [EW-1:0] col_inc, row_inc;
    logic          rend, gend;
    logic [15:0]   alpha_prod;
    logic [7:0]    alpha;
    logic [7:0]    blend_alpha;
    logic [8:0]    weight_sum;

    function automatic logic [EW-1:0] eff_dim(input logic [rgbfb_pkg::DIM_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (v == '0)
        begin
            return EW'(1);
        end
        else if (ext > EW'(MAX_DIM))
        begin
            return EW'(MAX_DIM);
        end
        return ext;
    endfunction

    assign q_write = push && !qstat.full;

    always_comb
    begin
        dim_w   = eff_dim(region_width);
        dim_h   = eff_dim(region_height);
        col_inc = EW'(col_reg) + EW'(1);
        row_inc = EW'(row_reg) + EW'(1);
        rend    = (col_inc >= dim_w);
        gend    = rend && (row_inc >= dim_h);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_write)
        begin
            if (rend)
            begin
                col_next = '0;
                row_next = gend ? '0 : row_inc[CW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        alpha_prod = 16'(mask_value) * 16'(opacity);
        alpha      = (opacity < rgbfb_pkg::OPACITY_FULL) ? alpha_prod[15:8] : mask_value;
    end

    always_comb
    begin
        blend_alpha = opacity;
        q_entry.op  = rgbfb_pkg::OP_KEEP;
        unique case (mode)
            rgbfb_pkg::MODE_SOLID:
            begin
                q_entry.op = rgbfb_pkg::OP_FILL;
            end
            rgbfb_pkg::MODE_OPACITY:
            begin
                q_entry.op = rgbfb_pkg::OP_BLEND;
            end
            rgbfb_pkg::MODE_MASKED:
            begin
                blend_alpha = alpha;
                if (alpha >= rgbfb_pkg::ALPHA_SOLID)
                begin
                    q_entry.op = rgbfb_pkg::OP_FILL;
                end
                else if (alpha > rgbfb_pkg::ALPHA_CLEAR)
                begin
                    q_entry.op = rgbfb_pkg::OP_BLEND;
                end
            end
            default:
            begin
                q_entry.op = rgbfb_pkg::OP_KEEP;
            end
        endcase
        weight_sum         = 9'(blend_alpha) + rgbfb_pkg::WEIGHT_ROUND;
        q_entry.weight     = weight_sum[8:3];
        q_entry.pixel      = dst_pixel;
        q_entry.row_end    = rend;
        q_entry.region_end = gend;
    end

endmodule

@@ hdl/rgbfb_queue.sv @@
// ----------------------------------------------------------------------------
// rgbfb_queue
// Short first-in first-out queue of classified pixels.
// ----------------------------------------------------------------------------
module rgbfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  rgbfb_pkg::entry_t wr_entry,
    input  logic              rd,
    output rgbfb_pkg::entry_t rd_entry,
    output rgbfb_pkg::qstat_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    rgbfb_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     rptr_reg, rptr_next;
    logic [NW-1:0]     count_reg, count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign qstat.full  = (count_reg == NW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign rd_entry    = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wr ? wrap_inc(wptr_reg) : wptr_reg;
        rptr_next  = rd ? wrap_inc(rptr_reg) : rptr_reg;
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wr_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> (!qstat.full || rd))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> !qstat.empty)
        else $error("read from empty queue");

endmodule

@@ hdl/rgbfb_back.sv @@
// ----------------------------------------------------------------------------
// rgbfb_back
// Fills, blends or keeps queued pixels and holds the result for the receiver.
// ----------------------------------------------------------------------------
module rgbfb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rgbfb_pkg::qstat_t qstat,
    input  rgbfb_pkg::entry_t q_entry,
    output logic              q_read,
    input  logic [15:0]       fill_color,
    input  logic              pop,
    output logic              empty,
    output logic [15:0]       out_pixel,
    output logic              write_enable,
    output logic              row_end,
    output logic              region_end
);

    logic        valid_reg, valid_next;
    logic [15:0] pixel_reg;
    logic        we_reg, rend_reg, gend_reg;

    logic [31:0] fg_spread, bg_spread, diff, prod, blended;
    logic [15:0] blend_pixel;
    logic [15:0] res_pixel;
    logic        res_we;
    logic        take;

    assign take   = !valid_reg || pop;
    assign q_read = take && !qstat.empty;

    always_comb
    begin
        fg_spread   = {fill_color, fill_color} & rgbfb_pkg::SPREAD_MASK;
        bg_spread   = {q_entry.pixel, q_entry.pixel} & rgbfb_pkg::SPREAD_MASK;
        diff        = fg_spread - bg_spread;
        prod        = diff * 32'(q_entry.weight);
        blended     = ((prod >> rgbfb_pkg::WEIGHT_SHIFT) + bg_spread) & rgbfb_pkg::SPREAD_MASK;
        blend_pixel = blended[31:16] | blended[15:0];
    end

    always_comb
    begin
        res_pixel = q_entry.pixel;
        res_we    = 1'b0;
        case (q_entry.op)
            rgbfb_pkg::OP_FILL:
            begin
                res_pixel = fill_color;
                res_we    = 1'b1;
            end
            rgbfb_pkg::OP_BLEND:
            begin
                res_pixel = blend_pixel;
                res_we    = 1'b1;
            end
            default:
            begin
                res_pixel = q_entry.pixel;
                res_we    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = !qstat.empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_read)
        begin
            pixel_reg <= res_pixel;
            we_reg    <= res_we;
            rend_reg  <= q_entry.row_end;
            gend_reg  <= q_entry.region_end;
        end
    end

    assign empty        = !valid_reg;
    assign out_pixel    = pixel_reg;
    assign write_enable = we_reg;
    assign row_end      = rend_reg;
    assign region_end   = gend_reg;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb565_fill_blend_unit.
// A driver pushes destination pixels with mask bytes and a monitor pops
// results; every accepted pixel is predicted in the bench and compared
// field by field against the popped beat. Register settings change only
// between drained phases: a directed opening covers every mode, opacity and
// mask extremes, clamped and resized regions, then random phases follow.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_DIM    = 4096;
    localparam int         IDLE_PCT   = 14;
    localparam int         CYCLE_CAP  = 200000;
    localparam int         RAND_PHASE = 13;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef struct {
        logic [15:0] pixel;
        logic [7:0]  mask;
    } pixel_beat_t;

    typedef struct {
        logic [15:0] pixel;
        logic        wr;
        logic        row_last;
        logic        region_last;
    } pixel_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b1;
    logic                             cfg_write = 1'b0;
    logic [rgbfb_pkg::CFG_IDX_W-1:0]  cfg_index = rgbfb_pkg::CFG_MODE;
    logic [rgbfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             push = 1'b0;
    logic                             full;
    logic [15:0]                      dst_pixel = '0;
    logic [7:0]                       mask_value = '0;
    logic                             pop = 1'b0;
    logic                             empty;
    logic [15:0]                      out_pixel;
    logic                             write_enable;
    logic                             row_end;
    logic                             region_end;

    logic [1:0]  cur_mode;
    logic [15:0] cur_color;
    logic [7:0]  cur_opacity;
    logic [12:0] cur_width;
    logic [12:0] cur_height;
    logic [11:0] col_pos;
    logic [11:0] row_pos;

    pixel_beat_t   pending_px[$];
    pixel_result_t awaited_px[$];
    pixel_beat_t   next_beat;
    pixel_result_t oldest;

    logic steady = 1'b0;
    int   error_count = 0;
    int   pixels_in = 0;
    int   results_out = 0;
    int   settings_seen = 0;
    int   cycle_count = 0;

    rgb565_fill_blend_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .dst_pixel    (dst_pixel),
        .mask_value   (mask_value),
        .pop          (pop),
        .empty        (empty),
        .out_pixel    (out_pixel),
        .write_enable (write_enable),
        .row_end      (row_end),
        .region_end   (region_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        if (v > 13'(MAX_DIM))
            return 13'(MAX_DIM);
        return v;
    endfunction

    function automatic logic [15:0] blend_rgb565(input logic [15:0] fg, input logic [15:0] bg,
                                                 input logic [7:0] alpha);
        logic [31:0] wt;
        logic [31:0] sb;
        logic [31:0] sf;
        logic [31:0] mix;
        wt  = ({24'd0, alpha} + 32'(rgbfb_pkg::WEIGHT_ROUND)) >> 3;
        sb  = {bg, bg} & rgbfb_pkg::SPREAD_MASK;
        sf  = {fg, fg} & rgbfb_pkg::SPREAD_MASK;
        mix = ((((sf - sb) * wt) >> rgbfb_pkg::WEIGHT_SHIFT) + sb) & rgbfb_pkg::SPREAD_MASK;
        return mix[31:16] | mix[15:0];
    endfunction

    function automatic void predict_pixel(input logic [15:0] px, input logic [7:0] mv);
        pixel_result_t r;
        logic [15:0]   prod;
        logic [7:0]    alpha;
        logic [12:0]   w;
        logic [12:0]   h;
        w     = clamp_dim(cur_width);
        h     = clamp_dim(cur_height);
        r.pixel = px;
        r.wr    = 1'b0;
        case (cur_mode)
            rgbfb_pkg::MODE_SOLID:
            begin
                r.pixel = cur_color;
                r.wr    = 1'b1;
            end
            rgbfb_pkg::MODE_OPACITY:
            begin
                r.pixel = blend_rgb565(cur_color, px, cur_opacity);
                r.wr    = 1'b1;
            end
            rgbfb_pkg::MODE_MASKED:
            begin
                alpha = mv;
                if (cur_opacity < rgbfb_pkg::OPACITY_FULL)
                begin
                    prod  = mv * cur_opacity;
                    alpha = prod[15:8];
                end
                if (alpha >= rgbfb_pkg::ALPHA_SOLID)
                begin
                    r.pixel = cur_color;
                    r.wr    = 1'b1;
                end
                else if (alpha > rgbfb_pkg::ALPHA_CLEAR)
                begin
                    r.pixel = blend_rgb565(cur_color, px, alpha);
                    r.wr    = 1'b1;
                end
            end
            default:
            begin
                r.wr = 1'b0;
            end
        endcase
        r.row_last    = ({1'b0, col_pos} + 13'd1) >= w;
        r.region_last = r.row_last && (({1'b0, row_pos} + 13'd1) >= h);
        if (r.row_last)
        begin
            col_pos = '0;
            row_pos = r.region_last ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 12'd1;
        end
        awaited_px.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h want %h at result %0d (t=%0t)",
                 what, got, want, results_out, $realtime);
        error_count++;
    endtask

    // driver: advance only when the current beat is taken or none is up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_pixel(dst_pixel, mask_value);
                pixels_in++;
            end
            if (!push || !full)
            begin
                if (pending_px.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_beat = pending_px.pop_front();
                    push       <= 1'b1;
                    dst_pixel  <= next_beat.pixel;
                    mask_value <= next_beat.mask;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_px.size() == 0)
                begin
                    report_mismatch("beat with nothing awaited", out_pixel, 16'h0000);
                end
                else
                begin
                    oldest = awaited_px.pop_front();
                    if (out_pixel !== oldest.pixel)
                        report_mismatch("out_pixel", out_pixel, oldest.pixel);
                    if (write_enable !== oldest.wr)
                        report_mismatch("write_enable", 16'(write_enable), 16'(oldest.wr));
                    if (row_end !== oldest.row_last)
                        report_mismatch("row_end", 16'(row_end), 16'(oldest.row_last));
                    if (region_end !== oldest.region_last)
                        report_mismatch("region_end", 16'(region_end),
                                        16'(oldest.region_last));
                end
                results_out++;
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results awaited", cycle_count,
                     awaited_px.size());
            $display("rgb565_fill_blend_unit regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [rgbfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            rgbfb_pkg::CFG_MODE:       cur_mode    = data[1:0];
            rgbfb_pkg::CFG_FILL_COLOR: cur_color   = data;
            rgbfb_pkg::CFG_OPACITY:    cur_opacity = data[7:0];
            rgbfb_pkg::CFG_WIDTH:      cur_width   = data[12:0];
            rgbfb_pkg::CFG_HEIGHT:     cur_height  = data[12:0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_seen++;
    endtask

    task automatic queue_px(input logic [15:0] px, input logic [7:0] mv);
        pixel_beat_t b;
        b.pixel = px;
        b.mask  = mv;
        pending_px.push_back(b);
    endtask

    // hold until every pushed pixel has come back, then settle
    task automatic drain();
        while (pending_px.size() != 0 || push || awaited_px.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dim(input int top);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(8191));
            default: return 16'($urandom_range(1, top));
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return rgbfb_pkg::MODE_SOLID;
        if (r < 5)
            return rgbfb_pkg::MODE_OPACITY;
        if (r < 9)
            return rgbfb_pkg::MODE_MASKED;
        return MODE_NONE;
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(3));
            3:       return 8'($urandom_range(250, 255));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    initial
    begin
        int n_items;
        logic [7:0] opa;
        rst_n       <= 1'b0;
        cur_mode    = rgbfb_pkg::MODE_SOLID;
        cur_color   = 16'h0000;
        cur_opacity = rgbfb_pkg::OPACITY_FULL;
        cur_width   = 13'd1;
        cur_height  = 13'd1;
        col_pos     = '0;
        row_pos     = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_px(16'h0000, 8'd0);
        queue_px(16'hFFFF, 8'd255);
        drain();

        write_reg(rgbfb_pkg::CFG_MODE, 16'(rgbfb_pkg::MODE_OPACITY));
        write_reg(rgbfb_pkg::CFG_FILL_COLOR, 16'hFFFF);
        write_reg(rgbfb_pkg::CFG_OPACITY, 16'd0);
        write_reg(rgbfb_pkg::CFG_WIDTH, 16'd4);
        write_reg(rgbfb_pkg::CFG_HEIGHT, 16'd2);
        queue_px(16'h0000, 8'd0);
        queue_px(16'hFFFF, 8'd0);
        drain();
        write_reg(rgbfb_pkg::CFG_OPACITY, 16'd128);
        queue_px(16'hF800, 8'd0);
        queue_px(16'h07E0, 8'd0);
        queue_px(16'h001F, 8'd0);
        drain();

        write_reg(rgbfb_pkg::CFG_MODE, 16'(rgbfb_pkg::MODE_MASKED));
        write_reg(rgbfb_pkg::CFG_FILL_COLOR, 16'h1234);
        write_reg(rgbfb_pkg::CFG_OPACITY, 16'(rgbfb_pkg::OPACITY_FULL));
        queue_px(16'hABCD, 8'd0);
        queue_px(16'hABCD, 8'd2);
        queue_px(16'hABCD, 8'd3);
        queue_px(16'h5555, 8'd252);
        queue_px(16'h5555, 8'd253);
        queue_px(16'hAAAA, 8'd255);
        drain();
        write_reg(rgbfb_pkg::CFG_OPACITY, 16'd254);
        queue_px(16'h8000, 8'd255);
        drain();
        write_reg(rgbfb_pkg::CFG_OPACITY, 16'd0);
        queue_px(16'h0001, 8'd255);
        drain();

        write_reg(rgbfb_pkg::CFG_MODE, 16'(MODE_NONE));
        write_reg(rgbfb_pkg::CFG_WIDTH, 16'd0);
        write_reg(rgbfb_pkg::CFG_HEIGHT, 16'd0);
        queue_px(16'hC3C3, 8'd128);
        queue_px(16'h3C3C, 8'd7);
        drain();

        // shrink the region while a row is half done
        write_reg(rgbfb_pkg::CFG_MODE, 16'(rgbfb_pkg::MODE_SOLID));
        write_reg(rgbfb_pkg::CFG_WIDTH, 16'd8);
        write_reg(rgbfb_pkg::CFG_HEIGHT, 16'd3);
        repeat (10) queue_px(pick_word(), pick_mask());
        drain();
        write_reg(rgbfb_pkg::CFG_WIDTH, 16'd2);
        write_reg(rgbfb_pkg::CFG_HEIGHT, 16'd1);
        queue_px(16'h7777, 8'd77);
        drain();

        for (int phase = 0; phase < RAND_PHASE; phase++)
        begin
            steady = (phase == 3);
            case ($urandom_range(5))
                0:       opa = 8'd0;
                1:       opa = rgbfb_pkg::OPACITY_FULL;
                2:       opa = 8'd254;
                default: opa = 8'($urandom_range(255));
            endcase
            write_reg(rgbfb_pkg::CFG_MODE, 16'(pick_mode()));
            write_reg(rgbfb_pkg::CFG_FILL_COLOR, pick_word());
            write_reg(rgbfb_pkg::CFG_OPACITY, 16'(opa));
            if (phase == 5)
            begin
                write_reg(rgbfb_pkg::CFG_WIDTH, 16'(MAX_DIM));
                write_reg(rgbfb_pkg::CFG_HEIGHT, 16'd2);
                n_items = 300;
            end
            else
            begin
                write_reg(rgbfb_pkg::CFG_WIDTH, pick_dim(12));
                write_reg(rgbfb_pkg::CFG_HEIGHT, pick_dim(6));
                n_items = 130;
            end
            repeat (n_items) queue_px(pick_word(), pick_mask());
            drain();
        end
        steady = 1'b0;

        repeat (8) @(posedge clk);
        if (awaited_px.size() != 0)
            report_mismatch("results never returned", 16'(awaited_px.size()), 16'h0000);

        $display("checked %0d pixels against %0d results across %0d register writes",
                 pixels_in, results_out, settings_seen);
        $display("all four modes, opacity and mask extremes, clamped and resized regions");
        if (error_count == 0)
            $display("rgb565_fill_blend_unit regression: pass");
        else
            $display("rgb565_fill_blend_unit regression: fail");
        $finish;
    end

endmodule
